>>> sv/circle_circle_collision_impulse_core_macros.svh
// ---------------------------------------------------------------------------
// circle_circle_collision_impulse_core_macros
// assertion macros used by the checker file of the impulse core
// ---------------------------------------------------------------------------
`ifndef CIRCLE_CIRCLE_COLLISION_IMPULSE_CORE_MACROS_SVH
`define CIRCLE_CIRCLE_COLLISION_IMPULSE_CORE_MACROS_SVH

// property checked while out of reset
`define CCI_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// property checked on every edge, reset included
`define CCI_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

>>> sv/cci_pkg.sv
// ---------------------------------------------------------------------------
// cci_pkg
// types and fixed widths of the circle collision impulse core
// ---------------------------------------------------------------------------
`default_nettype none

package cci_pkg;

   localparam int unsigned RESTITUTION_W = 17;
   localparam int unsigned RADIUS_W      = 31;
   localparam int unsigned DIFF_W        = 33;   // signed difference of two Q16.16 values
   localparam int unsigned MAG_W         = 33;   // magnitude of a difference
   localparam int unsigned SQ_W          = 66;   // product of two magnitudes
   localparam int unsigned DIST_W        = 66;   // squared distance and dot magnitude
   localparam int unsigned HALF_W        = 33;   // split of the dot magnitude
   localparam int unsigned NUM_W         = 99;   // dot * component
   localparam int unsigned Q_W           = 35;   // quotient bits of every divider
   localparam int unsigned T_W           = 34;   // useful quotient bits of t
   localparam int unsigned RSUM_W        = 32;
   localparam int unsigned RSQ_W         = 64;
   localparam int unsigned MPROD_W       = 64;
   localparam int unsigned MSUM_W        = 33;
   localparam int unsigned MU_W          = 32;
   localparam int unsigned GAIN_W        = 18;   // 1 + e in Q2.16
   localparam int unsigned KPROD_W       = 50;
   localparam int unsigned K_W           = 34;
   localparam int unsigned IPROD_W       = 68;
   localparam int unsigned IMAG_W        = 52;
   localparam int unsigned FRAC_W        = 16;
   localparam int unsigned OUT_W         = 32;

   localparam logic [GAIN_W-1:0]        GAIN_ONE          = 18'h1_0000;
   localparam logic [RESTITUTION_W-1:0] RESTITUTION_RESET = 17'h1_0000;
   localparam logic [OUT_W-1:0]         POS_LIMIT         = 32'h7FFF_FFFF;
   localparam logic [OUT_W-1:0]         NEG_LIMIT         = 32'h8000_0000;

   // request word, last member in the lowest bits
   typedef struct packed {
      logic [RADIUS_W-1:0] b_radius;
      logic [RADIUS_W-1:0] a_radius;
      logic [31:0]         b_mass;
      logic [31:0]         a_mass;
      logic signed [31:0]  b_vel_y;
      logic signed [31:0]  b_vel_x;
      logic signed [31:0]  a_vel_y;
      logic signed [31:0]  a_vel_x;
      logic signed [31:0]  b_pos_y;
      logic signed [31:0]  b_pos_x;
      logic signed [31:0]  a_pos_y;
      logic signed [31:0]  a_pos_x;
   } req_type;

   // response word, last member in the lowest bits
   typedef struct packed {
      logic               overflow;
      logic               degenerate;
      logic signed [31:0] impulse_y;
      logic signed [31:0] impulse_x;
      logic               colliding;
   } rsp_type;

   // per-item flags carried past the dividers
   typedef struct packed {
      logic colliding;
      logic degenerate;
      logic mass_zero;
      logic neg_x;
      logic neg_y;
   } flags_type;

   localparam int unsigned REQ_W       = $bits(req_type);
   localparam int unsigned REQ_TDATA_W = 384;
   localparam int unsigned RSP_W       = $bits(rsp_type);
   localparam int unsigned RSP_TDATA_W = 72;

endpackage

`default_nettype wire

>>> sv/cci_front.sv
// ---------------------------------------------------------------------------
// cci_front
// six stages: differences, magnitudes, products, squared distance and dot,
// collision compare, divider numerators
// ---------------------------------------------------------------------------
`default_nettype none

module cci_front (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 adv,
   input  wire logic                                 in_valid,
   input  wire cci_pkg::req_type                     in_req,
   output logic                                      out_valid,
   output logic [cci_pkg::NUM_W-1:0]                 out_num_x,
   output logic [cci_pkg::NUM_W-1:0]                 out_num_y,
   output logic [cci_pkg::DIST_W-1:0]                out_dist2,
   output logic [cci_pkg::MPROD_W-1:0]               out_mprod,
   output logic [cci_pkg::MSUM_W-1:0]                out_msum,
   output cci_pkg::flags_type                        out_flags
);

   // stage 1: differences, mass product and sums
   logic                                 s1_v_ff;
   logic signed [cci_pkg::DIFF_W-1:0]    s1_dx_in, s1_dy_in, s1_vx_in, s1_vy_in;
   logic signed [cci_pkg::DIFF_W-1:0]    s1_dx_ff, s1_dy_ff, s1_vx_ff, s1_vy_ff;
   logic [cci_pkg::MPROD_W-1:0]          s1_mprod_in, s1_mprod_ff;
   logic [cci_pkg::MSUM_W-1:0]           s1_msum_in, s1_msum_ff;
   logic [cci_pkg::RSUM_W-1:0]           s1_rsum_in, s1_rsum_ff;

   always_comb begin
      s1_dx_in    = cci_pkg::DIFF_W'(in_req.a_pos_x) - cci_pkg::DIFF_W'(in_req.b_pos_x);
      s1_dy_in    = cci_pkg::DIFF_W'(in_req.a_pos_y) - cci_pkg::DIFF_W'(in_req.b_pos_y);
      s1_vx_in    = cci_pkg::DIFF_W'(in_req.b_vel_x) - cci_pkg::DIFF_W'(in_req.a_vel_x);
      s1_vy_in    = cci_pkg::DIFF_W'(in_req.b_vel_y) - cci_pkg::DIFF_W'(in_req.a_vel_y);
      s1_mprod_in = cci_pkg::MPROD_W'(in_req.a_mass) * cci_pkg::MPROD_W'(in_req.b_mass);
      s1_msum_in  = cci_pkg::MSUM_W'(in_req.a_mass) + cci_pkg::MSUM_W'(in_req.b_mass);
      s1_rsum_in  = cci_pkg::RSUM_W'(in_req.a_radius) + cci_pkg::RSUM_W'(in_req.b_radius);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
      end else if (adv) begin
         s1_v_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_dx_ff    <= s1_dx_in;
         s1_dy_ff    <= s1_dy_in;
         s1_vx_ff    <= s1_vx_in;
         s1_vy_ff    <= s1_vy_in;
         s1_mprod_ff <= s1_mprod_in;
         s1_msum_ff  <= s1_msum_in;
         s1_rsum_ff  <= s1_rsum_in;
      end
   end

   // stage 2: magnitudes, signs, radius sum squared
   logic                          s2_v_ff;
   logic [cci_pkg::MAG_W-1:0]     s2_adx_in, s2_ady_in, s2_avx_in, s2_avy_in;
   logic [cci_pkg::MAG_W-1:0]     s2_adx_ff, s2_ady_ff, s2_avx_ff, s2_avy_ff;
   logic                          s2_sx_in, s2_sy_in, s2_dxneg_in, s2_dyneg_in;
   logic                          s2_sx_ff, s2_sy_ff, s2_dxneg_ff, s2_dyneg_ff;
   logic                          s2_degen_in, s2_degen_ff, s2_mzero_in, s2_mzero_ff;
   logic [cci_pkg::RSQ_W-1:0]     s2_rsq_in, s2_rsq_ff;
   logic [cci_pkg::MPROD_W-1:0]   s2_mprod_ff;
   logic [cci_pkg::MSUM_W-1:0]    s2_msum_ff;

   always_comb begin
      s2_adx_in   = s1_dx_ff[cci_pkg::DIFF_W-1] ? cci_pkg::MAG_W'(-s1_dx_ff)
                                                : cci_pkg::MAG_W'(s1_dx_ff);
      s2_ady_in   = s1_dy_ff[cci_pkg::DIFF_W-1] ? cci_pkg::MAG_W'(-s1_dy_ff)
                                                : cci_pkg::MAG_W'(s1_dy_ff);
      s2_avx_in   = s1_vx_ff[cci_pkg::DIFF_W-1] ? cci_pkg::MAG_W'(-s1_vx_ff)
                                                : cci_pkg::MAG_W'(s1_vx_ff);
      s2_avy_in   = s1_vy_ff[cci_pkg::DIFF_W-1] ? cci_pkg::MAG_W'(-s1_vy_ff)
                                                : cci_pkg::MAG_W'(s1_vy_ff);
      s2_dxneg_in = s1_dx_ff[cci_pkg::DIFF_W-1];
      s2_dyneg_in = s1_dy_ff[cci_pkg::DIFF_W-1];
      s2_sx_in    = s1_vx_ff[cci_pkg::DIFF_W-1] ^ s1_dx_ff[cci_pkg::DIFF_W-1];
      s2_sy_in    = s1_vy_ff[cci_pkg::DIFF_W-1] ^ s1_dy_ff[cci_pkg::DIFF_W-1];
      s2_degen_in = (s1_dx_ff == '0) && (s1_dy_ff == '0);
      s2_mzero_in = (s1_msum_ff == '0);
      s2_rsq_in   = cci_pkg::RSQ_W'(s1_rsum_ff) * cci_pkg::RSQ_W'(s1_rsum_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_v_ff <= 1'b0;
      end else if (adv) begin
         s2_v_ff <= s1_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s2_adx_ff   <= s2_adx_in;
         s2_ady_ff   <= s2_ady_in;
         s2_avx_ff   <= s2_avx_in;
         s2_avy_ff   <= s2_avy_in;
         s2_sx_ff    <= s2_sx_in;
         s2_sy_ff    <= s2_sy_in;
         s2_dxneg_ff <= s2_dxneg_in;
         s2_dyneg_ff <= s2_dyneg_in;
         s2_degen_ff <= s2_degen_in;
         s2_mzero_ff <= s2_mzero_in;
         s2_rsq_ff   <= s2_rsq_in;
         s2_mprod_ff <= s1_mprod_ff;
         s2_msum_ff  <= s1_msum_ff;
      end
   end

   // stage 3: the four magnitude products
   logic                          s3_v_ff;
   logic [cci_pkg::SQ_W-1:0]      s3_px_in, s3_py_in, s3_dxx_in, s3_dyy_in;
   logic [cci_pkg::SQ_W-1:0]      s3_px_ff, s3_py_ff, s3_dxx_ff, s3_dyy_ff;
   logic [cci_pkg::MAG_W-1:0]     s3_adx_ff, s3_ady_ff;
   logic                          s3_sx_ff, s3_sy_ff, s3_dxneg_ff, s3_dyneg_ff;
   logic                          s3_degen_ff, s3_mzero_ff;
   logic [cci_pkg::RSQ_W-1:0]     s3_rsq_ff;
   logic [cci_pkg::MPROD_W-1:0]   s3_mprod_ff;
   logic [cci_pkg::MSUM_W-1:0]    s3_msum_ff;

   always_comb begin
      s3_px_in  = cci_pkg::SQ_W'(s2_avx_ff) * cci_pkg::SQ_W'(s2_adx_ff);
      s3_py_in  = cci_pkg::SQ_W'(s2_avy_ff) * cci_pkg::SQ_W'(s2_ady_ff);
      s3_dxx_in = cci_pkg::SQ_W'(s2_adx_ff) * cci_pkg::SQ_W'(s2_adx_ff);
      s3_dyy_in = cci_pkg::SQ_W'(s2_ady_ff) * cci_pkg::SQ_W'(s2_ady_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_v_ff <= 1'b0;
      end else if (adv) begin
         s3_v_ff <= s2_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s3_px_ff    <= s3_px_in;
         s3_py_ff    <= s3_py_in;
         s3_dxx_ff   <= s3_dxx_in;
         s3_dyy_ff   <= s3_dyy_in;
         s3_adx_ff   <= s2_adx_ff;
         s3_ady_ff   <= s2_ady_ff;
         s3_sx_ff    <= s2_sx_ff;
         s3_sy_ff    <= s2_sy_ff;
         s3_dxneg_ff <= s2_dxneg_ff;
         s3_dyneg_ff <= s2_dyneg_ff;
         s3_degen_ff <= s2_degen_ff;
         s3_mzero_ff <= s2_mzero_ff;
         s3_rsq_ff   <= s2_rsq_ff;
         s3_mprod_ff <= s2_mprod_ff;
         s3_msum_ff  <= s2_msum_ff;
      end
   end

   // stage 4: squared distance and signed dot product as sign and magnitude
   logic                          s4_v_ff;
   logic [cci_pkg::DIST_W-1:0]    s4_dist2_in, s4_dist2_ff, s4_dot_in, s4_dot_ff;
   logic                          s4_dotneg_in, s4_dotneg_ff;
   logic [cci_pkg::MAG_W-1:0]     s4_adx_ff, s4_ady_ff;
   logic                          s4_dxneg_ff, s4_dyneg_ff, s4_degen_ff, s4_mzero_ff;
   logic [cci_pkg::RSQ_W-1:0]     s4_rsq_ff;
   logic [cci_pkg::MPROD_W-1:0]   s4_mprod_ff;
   logic [cci_pkg::MSUM_W-1:0]    s4_msum_ff;

   always_comb begin
      s4_dist2_in = cci_pkg::DIST_W'(s3_dxx_ff) + cci_pkg::DIST_W'(s3_dyy_ff);
      priority if (s3_sx_ff == s3_sy_ff) begin
         s4_dot_in    = s3_px_ff + s3_py_ff;
         s4_dotneg_in = s3_sx_ff;
      end else if (s3_px_ff < s3_py_ff) begin
         s4_dot_in    = s3_py_ff - s3_px_ff;
         s4_dotneg_in = s3_sy_ff;
      end else begin
         s4_dot_in    = s3_px_ff - s3_py_ff;
         s4_dotneg_in = s3_sx_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_v_ff <= 1'b0;
      end else if (adv) begin
         s4_v_ff <= s3_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s4_dist2_ff  <= s4_dist2_in;
         s4_dot_ff    <= s4_dot_in;
         s4_dotneg_ff <= s4_dotneg_in;
         s4_adx_ff    <= s3_adx_ff;
         s4_ady_ff    <= s3_ady_ff;
         s4_dxneg_ff  <= s3_dxneg_ff;
         s4_dyneg_ff  <= s3_dyneg_ff;
         s4_degen_ff  <= s3_degen_ff;
         s4_mzero_ff  <= s3_mzero_ff;
         s4_rsq_ff    <= s3_rsq_ff;
         s4_mprod_ff  <= s3_mprod_ff;
         s4_msum_ff   <= s3_msum_ff;
      end
   end

   // stage 5: overlap compare and partial numerator products
   logic                          s5_v_ff;
   logic [cci_pkg::SQ_W-1:0]      s5_lox_in, s5_hix_in, s5_loy_in, s5_hiy_in;
   logic [cci_pkg::SQ_W-1:0]      s5_lox_ff, s5_hix_ff, s5_loy_ff, s5_hiy_ff;
   cci_pkg::flags_type            s5_flags_in, s5_flags_ff;
   logic [cci_pkg::DIST_W-1:0]    s5_dist2_ff;
   logic [cci_pkg::MPROD_W-1:0]   s5_mprod_ff;
   logic [cci_pkg::MSUM_W-1:0]    s5_msum_ff;

   always_comb begin
      s5_flags_in.colliding  = s4_dist2_ff < cci_pkg::DIST_W'(s4_rsq_ff);
      s5_flags_in.degenerate = s4_degen_ff;
      s5_flags_in.mass_zero  = s4_mzero_ff;
      s5_flags_in.neg_x      = s4_dotneg_ff ^ s4_dxneg_ff;
      s5_flags_in.neg_y      = s4_dotneg_ff ^ s4_dyneg_ff;
      s5_lox_in = cci_pkg::SQ_W'(s4_dot_ff[cci_pkg::HALF_W-1:0]) * cci_pkg::SQ_W'(s4_adx_ff);
      s5_hix_in = cci_pkg::SQ_W'(s4_dot_ff[cci_pkg::DIST_W-1:cci_pkg::HALF_W])
                  * cci_pkg::SQ_W'(s4_adx_ff);
      s5_loy_in = cci_pkg::SQ_W'(s4_dot_ff[cci_pkg::HALF_W-1:0]) * cci_pkg::SQ_W'(s4_ady_ff);
      s5_hiy_in = cci_pkg::SQ_W'(s4_dot_ff[cci_pkg::DIST_W-1:cci_pkg::HALF_W])
                  * cci_pkg::SQ_W'(s4_ady_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s5_v_ff <= 1'b0;
      end else if (adv) begin
         s5_v_ff <= s4_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s5_lox_ff   <= s5_lox_in;
         s5_hix_ff   <= s5_hix_in;
         s5_loy_ff   <= s5_loy_in;
         s5_hiy_ff   <= s5_hiy_in;
         s5_flags_ff <= s5_flags_in;
         s5_dist2_ff <= s4_dist2_ff;
         s5_mprod_ff <= s4_mprod_ff;
         s5_msum_ff  <= s4_msum_ff;
      end
   end

   // stage 6: merge partial products into full numerators
   logic                          s6_v_ff;
   logic [cci_pkg::NUM_W-1:0]     s6_numx_in, s6_numy_in, s6_numx_ff, s6_numy_ff;
   cci_pkg::flags_type            s6_flags_ff;
   logic [cci_pkg::DIST_W-1:0]    s6_dist2_ff;
   logic [cci_pkg::MPROD_W-1:0]   s6_mprod_ff;
   logic [cci_pkg::MSUM_W-1:0]    s6_msum_ff;

   always_comb begin
      s6_numx_in = cci_pkg::NUM_W'(s5_lox_ff)
                   + (cci_pkg::NUM_W'(s5_hix_ff) << cci_pkg::HALF_W);
      s6_numy_in = cci_pkg::NUM_W'(s5_loy_ff)
                   + (cci_pkg::NUM_W'(s5_hiy_ff) << cci_pkg::HALF_W);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s6_v_ff <= 1'b0;
      end else if (adv) begin
         s6_v_ff <= s5_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s6_numx_ff  <= s6_numx_in;
         s6_numy_ff  <= s6_numy_in;
         s6_flags_ff <= s5_flags_ff;
         s6_dist2_ff <= s5_dist2_ff;
         s6_mprod_ff <= s5_mprod_ff;
         s6_msum_ff  <= s5_msum_ff;
      end
   end

   assign out_valid = s6_v_ff;
   assign out_num_x = s6_numx_ff;
   assign out_num_y = s6_numy_ff;
   assign out_dist2 = s6_dist2_ff;
   assign out_mprod = s6_mprod_ff;
   assign out_msum  = s6_msum_ff;
   assign out_flags = s6_flags_ff;

endmodule

`default_nettype wire

>>> sv/cci_div.sv
// ---------------------------------------------------------------------------
// cci_div
// pipelined restoring divider, one quotient bit per stage
// ---------------------------------------------------------------------------
`default_nettype none

module cci_div #(
   parameter int unsigned NUM_W  = 99,
   parameter int unsigned DEN_W  = 66,
   parameter int unsigned Q_W    = 35,
   parameter int unsigned SIDE_W = 1
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 adv,
   input  wire logic                 in_valid,
   input  wire logic [NUM_W-1:0]     in_num,
   input  wire logic [DEN_W-1:0]     in_den,
   input  wire logic [SIDE_W-1:0]    in_side,
   output logic                      out_valid,
   output logic [Q_W-1:0]            out_quot,
   output logic [SIDE_W-1:0]         out_side
);

   // the quotient must fit in Q_W bits, so the top of the numerator is
   // already below the divisor and seeds the partial remainder
   logic [DEN_W-1:0]  rem_src  [Q_W];
   logic [Q_W-1:0]    bits_src [Q_W];
   logic [DEN_W-1:0]  den_src  [Q_W];
   logic [SIDE_W-1:0] side_src [Q_W];
   logic              v_src    [Q_W];

   logic [DEN_W-1:0]  rem_in   [Q_W];
   logic [Q_W-1:0]    bits_in  [Q_W];

   logic [DEN_W-1:0]  rem_ff   [Q_W];
   logic [Q_W-1:0]    bits_ff  [Q_W];
   logic [DEN_W-1:0]  den_ff   [Q_W];
   logic [SIDE_W-1:0] side_ff  [Q_W];
   logic              v_ff     [Q_W];

   for (genvar i = 0; i < Q_W; i++) begin : g_step
      logic [DEN_W+1:0] shifted;
      logic [DEN_W+1:0] diff;
      logic             fits;

      if (i == 0) begin : g_head
         assign rem_src[i]  = DEN_W'(in_num[NUM_W-1:Q_W]);
         assign bits_src[i] = in_num[Q_W-1:0];
         assign den_src[i]  = in_den;
         assign side_src[i] = in_side;
         assign v_src[i]    = in_valid;
      end else begin : g_link
         assign rem_src[i]  = rem_ff[i-1];
         assign bits_src[i] = bits_ff[i-1];
         assign den_src[i]  = den_ff[i-1];
         assign side_src[i] = side_ff[i-1];
         assign v_src[i]    = v_ff[i-1];
      end

      // bring down one numerator bit, trial subtract, shift in the quotient bit
      assign shifted    = {1'b0, rem_src[i], bits_src[i][Q_W-1]};
      assign diff       = shifted - {2'b00, den_src[i]};
      assign fits       = ~diff[DEN_W+1];
      assign rem_in[i]  = fits ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
      assign bits_in[i] = {bits_src[i][Q_W-2:0], fits};

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[i] <= 1'b0;
         end else if (adv) begin
            v_ff[i] <= v_src[i];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            rem_ff[i]  <= rem_in[i];
            bits_ff[i] <= bits_in[i];
            den_ff[i]  <= den_src[i];
            side_ff[i] <= side_src[i];
         end
      end
   end

   assign out_valid = v_ff[Q_W-1];
   assign out_quot  = bits_ff[Q_W-1];
   assign out_side  = side_ff[Q_W-1];

endmodule

`default_nettype wire

>>> sv/cci_tail.sv
// ---------------------------------------------------------------------------
// cci_tail
// three stages: scaled reduced mass, impulse products, truncation and clamp
// ---------------------------------------------------------------------------
`default_nettype none

module cci_tail (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 adv,
   input  wire logic                                 in_valid,
   input  wire logic [cci_pkg::Q_W-1:0]              in_quot_mu,
   input  wire logic [cci_pkg::Q_W-1:0]              in_quot_x,
   input  wire logic [cci_pkg::Q_W-1:0]              in_quot_y,
   input  wire cci_pkg::flags_type                   in_flags,
   input  wire logic [cci_pkg::RESTITUTION_W-1:0]    restitution,
   output logic                                      out_valid,
   output cci_pkg::rsp_type                          out_rsp
);

   // clamp a sign and magnitude to the 32-bit signed range
   function automatic logic [cci_pkg::OUT_W:0] clamp(input logic neg,
                                                     input logic [cci_pkg::IMAG_W-1:0] mag);
      logic [cci_pkg::OUT_W:0] res;
      priority if (!neg && (mag > cci_pkg::IMAG_W'(cci_pkg::POS_LIMIT))) begin
         res = {1'b1, cci_pkg::POS_LIMIT};
      end else if (neg && (mag > cci_pkg::IMAG_W'(cci_pkg::NEG_LIMIT))) begin
         res = {1'b1, cci_pkg::NEG_LIMIT};
      end else if (neg) begin
         res = {1'b0, cci_pkg::OUT_W'(-mag)};
      end else begin
         res = {1'b0, mag[cci_pkg::OUT_W-1:0]};
      end
      return res;
   endfunction

   // stage 1: reduced mass times one plus restitution
   logic                           t1_v_ff;
   logic [cci_pkg::MU_W-1:0]       t1_mu;
   logic [cci_pkg::KPROD_W-1:0]    t1_kprod_in, t1_kprod_ff;
   logic [cci_pkg::T_W-1:0]        t1_tx_ff, t1_ty_ff;
   cci_pkg::flags_type             t1_flags_ff;

   always_comb begin
      t1_mu       = in_flags.mass_zero ? '0 : in_quot_mu[cci_pkg::MU_W-1:0];
      t1_kprod_in = cci_pkg::KPROD_W'(cci_pkg::GAIN_W'(restitution) + cci_pkg::GAIN_ONE)
                    * cci_pkg::KPROD_W'(t1_mu);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         t1_v_ff <= 1'b0;
      end else if (adv) begin
         t1_v_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         t1_kprod_ff <= t1_kprod_in;
         t1_tx_ff    <= in_quot_x[cci_pkg::T_W-1:0];
         t1_ty_ff    <= in_quot_y[cci_pkg::T_W-1:0];
         t1_flags_ff <= in_flags;
      end
   end

   // stage 2: gain times projected velocity per axis
   logic                           t2_v_ff;
   logic [cci_pkg::K_W-1:0]        t2_k;
   logic [cci_pkg::IPROD_W-1:0]    t2_px_in, t2_py_in, t2_px_ff, t2_py_ff;
   cci_pkg::flags_type             t2_flags_ff;

   always_comb begin
      t2_k     = t1_kprod_ff[cci_pkg::KPROD_W-1:cci_pkg::FRAC_W];
      t2_px_in = cci_pkg::IPROD_W'(t2_k) * cci_pkg::IPROD_W'(t1_tx_ff);
      t2_py_in = cci_pkg::IPROD_W'(t2_k) * cci_pkg::IPROD_W'(t1_ty_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         t2_v_ff <= 1'b0;
      end else if (adv) begin
         t2_v_ff <= t1_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         t2_px_ff    <= t2_px_in;
         t2_py_ff    <= t2_py_in;
         t2_flags_ff <= t1_flags_ff;
      end
   end

   // stage 3: drop fraction, apply sign, clamp, zero on coincident centres
   logic                           t3_v_ff;
   logic [cci_pkg::OUT_W:0]        t3_cx, t3_cy;
   cci_pkg::rsp_type               t3_rsp_in, t3_rsp_ff;

   always_comb begin
      t3_cx = clamp(t2_flags_ff.neg_x, t2_px_ff[cci_pkg::IPROD_W-1:cci_pkg::FRAC_W]);
      t3_cy = clamp(t2_flags_ff.neg_y, t2_py_ff[cci_pkg::IPROD_W-1:cci_pkg::FRAC_W]);
      t3_rsp_in.colliding  = t2_flags_ff.colliding;
      t3_rsp_in.degenerate = t2_flags_ff.degenerate;
      if (t2_flags_ff.degenerate) begin
         t3_rsp_in.impulse_x = '0;
         t3_rsp_in.impulse_y = '0;
         t3_rsp_in.overflow  = 1'b0;
      end else begin
         t3_rsp_in.impulse_x = t3_cx[cci_pkg::OUT_W-1:0];
         t3_rsp_in.impulse_y = t3_cy[cci_pkg::OUT_W-1:0];
         t3_rsp_in.overflow  = t3_cx[cci_pkg::OUT_W] | t3_cy[cci_pkg::OUT_W];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         t3_v_ff <= 1'b0;
      end else if (adv) begin
         t3_v_ff <= t2_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         t3_rsp_ff <= t3_rsp_in;
      end
   end

   assign out_valid = t3_v_ff;
   assign out_rsp   = t3_rsp_ff;

endmodule

`default_nettype wire

>>> sv/circle_circle_collision_impulse_core.sv
// depth: 6 front stages, 35 divider stages, 3 tail stages, 1 output register from an
// accepted req word to rsp_tvalid; the divider pipeline sets the depth
// throughput: one word per cycle while the response stream does not stall
// reset: synchronous, clears every valid bit and sets restitution to 1.0
// ---------------------------------------------------------------------------
// circle_circle_collision_impulse_core
// circle overlap test and restitution impulse on body A, fixed point
// ---------------------------------------------------------------------------
`default_nettype none

module circle_circle_collision_impulse_core (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   // csr port
   input  wire logic                                  csr_wr_en,
   input  wire logic [cci_pkg::RESTITUTION_W-1:0]     csr_wr_data,
   // request stream
   input  wire logic                                  req_tvalid,
   output logic                                       req_tready,
   // a_pos_x, a_pos_y, b_pos_x, b_pos_y, a_vel_x, a_vel_y, b_vel_x, b_vel_y,
   // a_mass, b_mass, a_radius, b_radius, zero pad (lowest bit up)
   input  wire logic [cci_pkg::REQ_TDATA_W-1:0]       req_tdata,
   // response stream
   output logic                                       rsp_tvalid,
   input  wire logic                                  rsp_tready,
   // colliding, impulse_x, impulse_y, degenerate, overflow, zero pad
   output logic [cci_pkg::RSP_TDATA_W-1:0]            rsp_tdata
);

   logic                                adv;
   cci_pkg::req_type                    req;
   logic [cci_pkg::RESTITUTION_W-1:0]   restitution_ff;

   logic                                fr_valid;
   logic [cci_pkg::NUM_W-1:0]           fr_num_x, fr_num_y;
   logic [cci_pkg::DIST_W-1:0]          fr_dist2;
   logic [cci_pkg::MPROD_W-1:0]         fr_mprod;
   logic [cci_pkg::MSUM_W-1:0]          fr_msum;
   cci_pkg::flags_type                  fr_flags;

   logic                                dv_valid;
   logic [cci_pkg::Q_W-1:0]             dv_quot_x, dv_quot_y, dv_quot_mu;
   logic [2:0]                          dv_side_x;
   logic                                dv_side_y, dv_side_mu;
   cci_pkg::flags_type                  dv_flags;

   logic                                tl_valid;
   cci_pkg::rsp_type                    tl_rsp;

   logic                                rsp_v_ff;
   cci_pkg::rsp_type                    rsp_data_ff;

   // restitution register
   always_ff @(posedge clock) begin
      if (reset) begin
         restitution_ff <= cci_pkg::RESTITUTION_RESET;
      end else if (csr_wr_en) begin
         restitution_ff <= csr_wr_data;
      end
   end

   // pipe holds only when the tail and output register are full and rsp_tready is low
   assign adv        = !(tl_valid && rsp_v_ff && !rsp_tready);
   assign req_tready = adv;
   assign req        = cci_pkg::req_type'(req_tdata[cci_pkg::REQ_W-1:0]);

   cci_front u_front (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (req_tvalid),
      .in_req    (req),
      .out_valid (fr_valid),
      .out_num_x (fr_num_x),
      .out_num_y (fr_num_y),
      .out_dist2 (fr_dist2),
      .out_mprod (fr_mprod),
      .out_msum  (fr_msum),
      .out_flags (fr_flags)
   );

   // the x lane carries colliding, degenerate and neg_x, the y lane neg_y, mu mass_zero
   cci_div #(
      .NUM_W  (cci_pkg::NUM_W),
      .DEN_W  (cci_pkg::DIST_W),
      .Q_W    (cci_pkg::Q_W),
      .SIDE_W (3)
   ) u_div_x (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (fr_valid),
      .in_num    (fr_num_x),
      .in_den    (fr_dist2),
      .in_side   ({fr_flags.colliding, fr_flags.degenerate, fr_flags.neg_x}),
      .out_valid (dv_valid),
      .out_quot  (dv_quot_x),
      .out_side  (dv_side_x)
   );

   cci_div #(
      .NUM_W  (cci_pkg::NUM_W),
      .DEN_W  (cci_pkg::DIST_W),
      .Q_W    (cci_pkg::Q_W),
      .SIDE_W (1)
   ) u_div_y (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (fr_valid),
      .in_num    (fr_num_y),
      .in_den    (fr_dist2),
      .in_side   (fr_flags.neg_y),
      .out_valid (),
      .out_quot  (dv_quot_y),
      .out_side  (dv_side_y)
   );

   // reduced mass: product over sum, same depth as the impulse lanes
   cci_div #(
      .NUM_W  (cci_pkg::MPROD_W),
      .DEN_W  (cci_pkg::MSUM_W),
      .Q_W    (cci_pkg::Q_W),
      .SIDE_W (1)
   ) u_div_mu (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (fr_valid),
      .in_num    (fr_mprod),
      .in_den    (fr_msum),
      .in_side   (fr_flags.mass_zero),
      .out_valid (),
      .out_quot  (dv_quot_mu),
      .out_side  (dv_side_mu)
   );

   always_comb begin
      dv_flags.colliding  = dv_side_x[2];
      dv_flags.degenerate = dv_side_x[1];
      dv_flags.neg_x      = dv_side_x[0];
      dv_flags.neg_y      = dv_side_y;
      dv_flags.mass_zero  = dv_side_mu;
   end

   cci_tail u_tail (
      .clock       (clock),
      .reset       (reset),
      .adv         (adv),
      .in_valid    (dv_valid),
      .in_quot_mu  (dv_quot_mu),
      .in_quot_x   (dv_quot_x),
      .in_quot_y   (dv_quot_y),
      .in_flags    (dv_flags),
      .restitution (restitution_ff),
      .out_valid   (tl_valid),
      .out_rsp     (tl_rsp)
   );

   // output register, loads whenever it is empty or being taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_v_ff <= 1'b0;
      end else if (!rsp_v_ff || rsp_tready) begin
         rsp_v_ff <= tl_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (!rsp_v_ff || rsp_tready) begin
         rsp_data_ff <= tl_rsp;
      end
   end

   assign rsp_tvalid = rsp_v_ff;
   assign rsp_tdata  = cci_pkg::RSP_TDATA_W'(rsp_data_ff);

endmodule

`default_nettype wire

>>> sv/cci_checker.sv
// ---------------------------------------------------------------------------
// cci_checker
// port-level checks of the impulse core, bound to the top level
// ---------------------------------------------------------------------------
`default_nettype none

`include "circle_circle_collision_impulse_core_macros.svh"

module cci_checker (
   input wire logic                              clock,
   input wire logic                              reset,
   input wire logic                              req_tvalid,
   input wire logic                              req_tready,
   input wire logic                              rsp_tvalid,
   input wire logic                              rsp_tready,
   input wire logic [cci_pkg::RSP_TDATA_W-1:0]   rsp_tdata
);

   cci_pkg::rsp_type rsp;
   logic             req_word;

   assign rsp      = cci_pkg::rsp_type'(rsp_tdata[cci_pkg::RSP_W-1:0]);
   assign req_word = req_tvalid && req_tready;

   // a stalled response word holds
   `CCI_ASSERT(a_rsp_hold, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata), "rsp word changed under stall")

   // no response right after reset, no request taken while in reset
   `CCI_ASSERT_ALWAYS(a_reset_empty, reset |=> !rsp_tvalid && !(reset && req_word), "rsp valid after reset")

   // coincident centres give a zero impulse and no clamp
   `CCI_ASSERT(a_degen_zero, rsp_tvalid && rsp.degenerate |-> rsp.impulse_x == '0 && rsp.impulse_y == '0 && !rsp.overflow, "degenerate word with impulse")

   // a clamp leaves at least one component at a range limit
   `CCI_ASSERT(a_ovf_limit, rsp_tvalid && rsp.overflow |-> rsp.impulse_x == cci_pkg::POS_LIMIT || rsp.impulse_x == cci_pkg::NEG_LIMIT || rsp.impulse_y == cci_pkg::POS_LIMIT || rsp.impulse_y == cci_pkg::NEG_LIMIT, "overflow without clamped impulse")

endmodule

bind circle_circle_collision_impulse_core cci_checker u_checker (.*);

`default_nettype wire
